FILE: rtl/core/mpt_pkg.sv
// ----------------------------------------------------------------------------
// mpt_pkg
// shared widths, codes, defaults and control structs of the process table core
// ----------------------------------------------------------------------------
package mpt_pkg;

  // default geometry
  localparam int SLOTS_DEF  = 16;
  localparam int LEVELS_DEF = 5;

  // field widths
  localparam int ACT_W   = 3;
  localparam int PID_W   = 16;
  localparam int ST_W    = 3;
  localparam int LVL_W   = 4;
  localparam int RT_W    = 32;
  localparam int TIME_W  = 64;
  localparam int PER_W   = 32;
  localparam int QB_W    = 24;
  localparam int THR_W   = QB_W + LVL_W + 1;
  localparam int WORD_W  = RT_W + LVL_W + ST_W + PID_W;

  // stream and config port widths
  localparam int S_TDATA_W  = 120;
  localparam int M_TDATA_W  = 56;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // output word bit positions
  localparam int OUT_LVL_LSB   = PID_W;
  localparam int OUT_RT_LSB    = PID_W + LVL_W;
  localparam int OUT_FOUND_BIT = PID_W + LVL_W + RT_W;
  localparam int OUT_FULL_BIT  = OUT_FOUND_BIT + 1;
  localparam int OUT_RESET_BIT = OUT_FOUND_BIT + 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FREE     = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FREE_ALL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SET_ST   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CHARGE   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_TICK     = 3'd5;

  // status codes
  localparam logic [ST_W-1:0] ST_UNUSED  = 3'd0;
  localparam logic [ST_W-1:0] ST_LOADING = 3'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_PERIOD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_BASE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHELL_PID    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_START   = 8'd3;

  // register reset values
  localparam logic [PER_W-1:0] RESET_PERIOD_DEF = 32'd10000000;
  localparam logic [QB_W-1:0]  QUANTUM_BASE_DEF = 24'd100000;
  localparam logic [PID_W-1:0] SHELL_PID_DEF    = 16'd4;
  localparam logic [PID_W-1:0] USER_START_DEF   = 16'd5;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic scan;
    logic demote;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic act_ok;
    logic scan_end;
    logic need_demote;
    logic demote_done;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/core/mpt_ctrl.sv
// ----------------------------------------------------------------------------
// mpt_ctrl
// sequencer of the process table: load, prepare, slot scan, demotion, result
// ----------------------------------------------------------------------------
module mpt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  mpt_pkg::sts_t sts,
  output mpt_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DEMOTE = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.act_ok ? S_SCAN : S_OUT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_end) begin
          state_next = sts.need_demote ? S_DEMOTE : S_OUT;
        end
      end
      S_DEMOTE: begin
        cmd.demote = 1'b1;
        if (sts.demote_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/mpt_dp.sv
// ----------------------------------------------------------------------------
// mpt_dp
// slot memory, scan pipeline, demotion unit, config and result registers
// ----------------------------------------------------------------------------
module mpt_dp #(
  parameter int SLOTS  = mpt_pkg::SLOTS_DEF,
  parameter int LEVELS = mpt_pkg::LEVELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [mpt_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [mpt_pkg::ACT_W-1:0]       s_tuser,
  input  logic                            cfg_valid,
  input  logic [mpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  mpt_pkg::cmd_t                   cmd,
  output mpt_pkg::sts_t                   sts,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mpt_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = SW + 1;
  localparam logic [CW-1:0] SLOTS_CNT = CW'(SLOTS);
  localparam logic [mpt_pkg::LVL_W-1:0] LAST_LVL = mpt_pkg::LVL_W'(LEVELS - 1);

  localparam int PID_W = mpt_pkg::PID_W;
  localparam int ST_W  = mpt_pkg::ST_W;
  localparam int LVL_W = mpt_pkg::LVL_W;
  localparam int RT_W  = mpt_pkg::RT_W;
  localparam int THR_W = mpt_pkg::THR_W;

  // config registers
  logic [mpt_pkg::PER_W-1:0] reset_period;
  logic [mpt_pkg::QB_W-1:0]  quantum_base;
  logic [PID_W-1:0]          shell_pid;
  logic [PID_W-1:0]          user_start_pid;

  // captured item
  logic [mpt_pkg::ACT_W-1:0]  act_q;
  logic [PID_W-1:0]           pid_q;
  logic [ST_W-1:0]            nst_q;
  logic [RT_W-1:0]            run_q;
  logic [mpt_pkg::TIME_W-1:0] now_q;
  logic                       tty_q;

  // persistent state
  logic [PID_W-1:0]           pid_counter;
  logic [mpt_pkg::TIME_W-1:0] last_reset;

  // slot memory, entries not yet written read as zero
  logic [mpt_pkg::WORD_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0]           slot_valid;
  logic [mpt_pkg::WORD_W-1:0] rd_q;
  logic                       rd_ok_q;

  // scan control
  logic [CW-1:0] issue_cnt;
  logic          rd_vld;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] ev_addr;
  logic          stop_q;
  logic          hit_q;
  logic          issue;
  logic          ev;

  // result and working registers
  logic [SW-1:0]    hit_addr;
  logic [PID_W-1:0] hit_pid;
  logic [ST_W-1:0]  hit_st;
  logic [LVL_W-1:0] cap_lvl;
  logic [RT_W-1:0]  cap_rt;
  logic [THR_W-1:0] thr_q;
  logic [PID_W-1:0] res_pid_q;
  logic             found_q;
  logic             full_q;
  logic             fire_q;

  // evaluated word
  logic [mpt_pkg::WORD_W-1:0] word;
  logic [PID_W-1:0]           w_pid;
  logic [ST_W-1:0]            w_st;
  logic [LVL_W-1:0]           w_lvl;
  logic [RT_W-1:0]            w_rt;
  logic                       w_live;
  logic                       w_match;
  logic                       w_shell;
  logic [RT_W:0]              sum_wide;
  logic [RT_W-1:0]            sum_sat;
  logic [THR_W-1:0]           thr_init;
  logic [PID_W-1:0]           pid_inc;

  // tick window
  logic [mpt_pkg::TIME_W-1:0] lrt_eff;
  logic [mpt_pkg::TIME_W-1:0] elapsed;
  logic                       fire;

  // demotion
  logic dem_go;

  // memory write port
  logic                       wr_en;
  logic [SW-1:0]              wr_addr;
  logic [mpt_pkg::WORD_W-1:0] wr_word;

  logic [PID_W-1:0] res_pid;

  assign rd_addr = issue_cnt[SW-1:0];
  assign issue   = cmd.scan && !stop_q && (issue_cnt != SLOTS_CNT);
  assign ev      = cmd.scan && rd_vld && !stop_q;

  assign word    = rd_ok_q ? rd_q : '0;
  assign w_pid   = word[PID_W-1:0];
  assign w_st    = word[PID_W +: ST_W];
  assign w_lvl   = word[PID_W+ST_W +: LVL_W];
  assign w_rt    = word[PID_W+ST_W+LVL_W +: RT_W];
  assign w_live  = (w_st != mpt_pkg::ST_UNUSED);
  assign w_match = w_live && (w_pid == pid_q);
  assign w_shell = w_live && (w_pid == shell_pid) && !hit_q;

  assign sum_wide = {1'b0, w_rt} + {1'b0, run_q};
  assign sum_sat  = sum_wide[RT_W] ? '1 : sum_wide[RT_W-1:0];
  assign thr_init = THR_W'(({1'b0, w_lvl} + (LVL_W+1)'(1)) * quantum_base);
  assign pid_inc  = pid_counter + PID_W'(1);

  assign lrt_eff = (last_reset == '0) ? now_q : last_reset;
  assign elapsed = now_q - lrt_eff;
  assign fire    = elapsed >= mpt_pkg::TIME_W'(reset_period);

  assign dem_go  = (cap_lvl < LAST_LVL) && (cap_rt > RT_W'(thr_q));

  assign sts.act_ok      = (act_q <= mpt_pkg::ACT_TICK);
  assign sts.scan_end    = stop_q || ((issue_cnt == SLOTS_CNT) && !rd_vld);
  assign sts.need_demote = (act_q == mpt_pkg::ACT_CHARGE) && hit_q;
  assign sts.demote_done = !dem_go;
  assign sts.out_free    = !m_tvalid || m_tready;

  // write port: scan updates in place, charge writes back after demotion
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ev_addr;
    wr_word = word;
    if (ev) begin
      unique case (act_q)
        mpt_pkg::ACT_ALLOC: begin
          if (!w_live) begin
            wr_en   = 1'b1;
            wr_word = {{RT_W{1'b0}}, {LVL_W{1'b0}}, mpt_pkg::ST_LOADING, pid_inc};
          end
        end
        mpt_pkg::ACT_FREE, mpt_pkg::ACT_SET_ST: begin
          if (w_match) begin
            wr_en   = 1'b1;
            wr_word = {w_rt, w_lvl,
                       (act_q == mpt_pkg::ACT_FREE) ? mpt_pkg::ST_UNUSED : nst_q, w_pid};
          end
        end
        mpt_pkg::ACT_FREE_ALL: begin
          if (w_live && (w_pid >= user_start_pid)) begin
            wr_en   = 1'b1;
            wr_word = {w_rt, w_lvl, mpt_pkg::ST_UNUSED, w_pid};
          end
        end
        mpt_pkg::ACT_TICK: begin
          if (w_live && (fire_q || (tty_q && w_shell))) begin
            wr_en   = 1'b1;
            wr_word = {{RT_W{1'b0}}, {LVL_W{1'b0}}, w_st, w_pid};
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
    if (cmd.demote && !dem_go) begin
      wr_en   = 1'b1;
      wr_addr = hit_addr;
      wr_word = {cap_rt, cap_lvl, hit_st, hit_pid};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    rd_q    <= mem[rd_addr];
    rd_ok_q <= slot_valid[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_period   <= mpt_pkg::RESET_PERIOD_DEF;
      quantum_base   <= mpt_pkg::QUANTUM_BASE_DEF;
      shell_pid      <= mpt_pkg::SHELL_PID_DEF;
      user_start_pid <= mpt_pkg::USER_START_DEF;
      pid_counter    <= '0;
      last_reset     <= '0;
      slot_valid     <= '0;
      issue_cnt      <= '0;
      rd_vld         <= 1'b0;
      stop_q         <= 1'b0;
      hit_q          <= 1'b0;
      found_q        <= 1'b0;
      full_q         <= 1'b0;
      fire_q         <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          mpt_pkg::CFG_RESET_PERIOD: reset_period   <= cfg_data;
          mpt_pkg::CFG_QUANTUM_BASE: quantum_base   <= cfg_data[mpt_pkg::QB_W-1:0];
          mpt_pkg::CFG_SHELL_PID:    shell_pid      <= cfg_data[PID_W-1:0];
          mpt_pkg::CFG_USER_START:   user_start_pid <= cfg_data[PID_W-1:0];
          default: begin
          end
        endcase
      end

      if (wr_en) begin
        slot_valid[wr_addr] <= 1'b1;
      end

      if (cmd.load) begin
        issue_cnt <= '0;
        rd_vld    <= 1'b0;
        stop_q    <= 1'b0;
        hit_q     <= 1'b0;
        found_q   <= 1'b0;
        full_q    <= 1'b0;
        fire_q    <= 1'b0;
      end

      if (cmd.prep && (act_q == mpt_pkg::ACT_TICK)) begin
        last_reset <= fire ? now_q : lrt_eff;
        fire_q     <= fire;
      end

      if (cmd.scan) begin
        rd_vld <= issue;
        if (issue) begin
          issue_cnt <= issue_cnt + CW'(1);
        end
        if (sts.scan_end && (act_q == mpt_pkg::ACT_ALLOC) && !hit_q) begin
          full_q <= 1'b1;
        end
      end

      if (ev) begin
        unique case (act_q)
          mpt_pkg::ACT_ALLOC: begin
            if (!w_live) begin
              hit_q       <= 1'b1;
              stop_q      <= 1'b1;
              pid_counter <= pid_inc;
            end
          end
          mpt_pkg::ACT_FREE, mpt_pkg::ACT_SET_ST: begin
            if (w_match) begin
              hit_q   <= 1'b1;
              found_q <= 1'b1;
            end
          end
          mpt_pkg::ACT_FREE_ALL: begin
            if (w_live && (w_pid >= user_start_pid)) begin
              found_q <= 1'b1;
            end
          end
          mpt_pkg::ACT_CHARGE: begin
            if (w_match) begin
              hit_q   <= 1'b1;
              stop_q  <= 1'b1;
              found_q <= 1'b1;
            end
          end
          mpt_pkg::ACT_TICK: begin
            if (w_shell) begin
              hit_q   <= 1'b1;
              found_q <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result word source
  always_comb begin
    unique case (act_q)
      mpt_pkg::ACT_ALLOC:                         res_pid = res_pid_q;
      mpt_pkg::ACT_FREE, mpt_pkg::ACT_SET_ST,
      mpt_pkg::ACT_CHARGE:                        res_pid = pid_q;
      mpt_pkg::ACT_TICK:                          res_pid = shell_pid;
      default:                                    res_pid = '0;
    endcase
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q     <= s_tuser;
      pid_q     <= s_tdata[15:0];
      nst_q     <= s_tdata[18:16];
      run_q     <= s_tdata[50:19];
      now_q     <= s_tdata[114:51];
      tty_q     <= s_tdata[115];
      cap_lvl   <= '0;
      cap_rt    <= '0;
      res_pid_q <= '0;
    end

    if (issue) begin
      ev_addr <= rd_addr;
    end

    if (ev) begin
      unique case (act_q)
        mpt_pkg::ACT_ALLOC: begin
          if (!w_live) begin
            res_pid_q <= pid_inc;
          end
        end
        mpt_pkg::ACT_FREE, mpt_pkg::ACT_SET_ST: begin
          if (w_match && !hit_q) begin
            cap_lvl <= w_lvl;
            cap_rt  <= w_rt;
          end
        end
        mpt_pkg::ACT_CHARGE: begin
          if (w_match) begin
            hit_addr <= ev_addr;
            hit_pid  <= w_pid;
            hit_st   <= w_st;
            cap_lvl  <= w_lvl;
            cap_rt   <= sum_sat;
            thr_q    <= thr_init;
          end
        end
        mpt_pkg::ACT_TICK: begin
          if (w_shell) begin
            cap_lvl <= (fire_q || tty_q) ? '0 : w_lvl;
            cap_rt  <= (fire_q || tty_q) ? '0 : w_rt;
          end
        end
        default: begin
        end
      endcase
    end

    // one demotion per cycle, threshold grows by one quantum per level
    if (cmd.demote && dem_go) begin
      cap_rt  <= cap_rt - RT_W'(thr_q);
      cap_lvl <= cap_lvl + LVL_W'(1);
      thr_q   <= thr_q + THR_W'(quantum_base);
    end

    if (cmd.finish) begin
      m_tdata <= {1'b0, fire_q, full_q, found_q, cap_rt, cap_lvl, res_pid};
    end
  end

endmodule

FILE: rtl/core/mlfq_process_table_core.sv
// ----------------------------------------------------------------------------
// mlfq_process_table_core
// process table of a multilevel feedback queue scheduler
// ----------------------------------------------------------------------------
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+------------------------------------
// s_      | in        | s_tvalid/s_tready  | s_tuser action, s_tdata request
// m_      | out       | m_tvalid/m_tready  | m_tdata result, one per request
// cfg_    | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// one request at a time: load, prepare, a scan of the slots, then for a charge
// that finds its pid the demotion steps and a write-back, then the result
// register load; the scan walks the single read port of the slot memory
// one slot per cycle; undefined actions skip the scan
// rst is synchronous; slots come up unused, no clearing pass is needed
// a result waiting on m_tready does not block the next request transfer;
// only the result register load waits for it
// cfg_ready is always high; the user must write registers only while idle,
// the block itself does not enforce it
module mlfq_process_table_core #(
  parameter int SLOTS  = mpt_pkg::SLOTS_DEF,   // 2 .. 256
  parameter int LEVELS = mpt_pkg::LEVELS_DEF   // 2 .. 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // request stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // pid[15:0], new_status[18:16], runtime_us[50:19], now_us[114:51],
  // tty_pending[115], zero pad [119:116]
  input  logic [mpt_pkg::S_TDATA_W-1:0]   s_tdata,
  // action[2:0]
  input  logic [mpt_pkg::ACT_W-1:0]       s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // result_pid[15:0], level_out[19:16], runtime_out[51:20], found[52],
  // table_full[53], levels_reset[54], zero pad [55]
  output logic [mpt_pkg::M_TDATA_W-1:0]   m_tdata,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mpt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mpt_pkg::cmd_t cmd;
  mpt_pkg::sts_t sts;

  // config transfer lands in the same cycle
  assign cfg_ready = 1'b1;

  // sequencer
  mpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot memory, scan and demotion datapath
  mpt_dp #(
    .SLOTS  (SLOTS),
    .LEVELS (LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: rtl/core/mpt_checker.sv
// ----------------------------------------------------------------------------
// mpt_checker
// port level checks of the process table core, bound to the top level
// ----------------------------------------------------------------------------
module mpt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mpt_pkg::M_TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // full table reports nothing else
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[mpt_pkg::OUT_FULL_BIT] |->
      m_tdata[mpt_pkg::OUT_FOUND_BIT:0] == '0)
    else $error("table full with nonzero fields");

  // a global level reset leaves the shell slot at level 0 with no runtime
  a_reset_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[mpt_pkg::OUT_RESET_BIT] |->
      m_tdata[mpt_pkg::OUT_FOUND_BIT-1:mpt_pkg::OUT_LVL_LSB] == '0)
    else $error("level reset with nonzero level or runtime");

endmodule

bind mlfq_process_table_core mpt_checker u_mpt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mlfq process table core: a shadow copy of the
// slot table predicts each result, requests stream in bursts, results drain
// under a stall pattern, registers change between phases while idle
// ----------------------------------------------------------------------------
module tb;
  import mpt_pkg::*;

  localparam int N_SLOTS       = SLOTS_DEF;
  localparam int N_LEVELS      = LEVELS_DEF;
  localparam int PAD_W         = S_TDATA_W - (PID_W + ST_W + RT_W + TIME_W + 1);
  localparam int SETTLE_CYCLES = 30;     // extra wait once all results are back
  localparam int ITEMS_HALF    = 850;
  localparam int ITEMS_PER_CFG = 140;

  // action and status codes the package leaves unnamed
  localparam logic [ACT_W-1:0] ACT_RSVD_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_RSVD_7 = 3'd7;
  localparam logic [ST_W-1:0]  ST_READY   = 3'd2;
  localparam logic [ST_W-1:0]  ST_RSVD_7  = 3'd7;

  // one result, same field order as m_tdata from the lsb up
  typedef struct packed {
    logic             levels_reset;
    logic             table_full;
    logic             found;
    logic [RT_W-1:0]  runtime;
    logic [LVL_W-1:0] level;
    logic [PID_W-1:0] pid;
  } sched_result_t;

  // shadow process table plus the replies it still owes
  class proc_table_tracker;
    logic [PER_W-1:0]  reset_period;
    logic [QB_W-1:0]   quantum;
    logic [PID_W-1:0]  shell_pid;
    logic [PID_W-1:0]  user_start;
    logic [PID_W-1:0]  slot_pid [N_SLOTS];
    logic [ST_W-1:0]   slot_st  [N_SLOTS];
    logic [LVL_W-1:0]  slot_lvl [N_SLOTS];
    logic [RT_W-1:0]   slot_rt  [N_SLOTS];
    logic [PID_W-1:0]  pid_ctr;
    logic [TIME_W-1:0] last_reset;
    sched_result_t     table_replies [$];
    int                errors;

    function new();
      reset_period = RESET_PERIOD_DEF;
      quantum      = QUANTUM_BASE_DEF;
      shell_pid    = SHELL_PID_DEF;
      user_start   = USER_START_DEF;
      for (int i = 0; i < N_SLOTS; i++) begin
        slot_pid[i] = '0;
        slot_st[i]  = ST_UNUSED;
        slot_lvl[i] = '0;
        slot_rt[i]  = '0;
      end
      pid_ctr    = '0;
      last_reset = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_RESET_PERIOD: reset_period = data;
        CFG_QUANTUM_BASE: quantum      = data[QB_W-1:0];
        CFG_SHELL_PID:    shell_pid    = data[PID_W-1:0];
        CFG_USER_START:   user_start   = data[PID_W-1:0];
        default: ;
      endcase
    endfunction

    function int find_live(logic [PID_W-1:0] pid);
      for (int i = 0; i < N_SLOTS; i++)
        if (slot_st[i] != ST_UNUSED && slot_pid[i] == pid) return i;
      return -1;
    endfunction

    function int live_count();
      int n;
      n = 0;
      for (int i = 0; i < N_SLOTS; i++)
        if (slot_st[i] != ST_UNUSED) n++;
      return n;
    endfunction

    // pid of the k-th live slot, counting from slot 0
    function logic [PID_W-1:0] live_pid(int k);
      int n;
      n = 0;
      for (int i = 0; i < N_SLOTS; i++)
        if (slot_st[i] != ST_UNUSED) begin
          if (n == k) return slot_pid[i];
          n++;
        end
      return '0;
    endfunction

    // saturating add, then demote while over the level allowance
    function void add_runtime(int s, logic [RT_W-1:0] run);
      logic [63:0] total;
      logic [63:0] allowance;
      bit          busy;
      total = 64'(slot_rt[s]) + 64'(run);
      if (total > 64'h0000_0000_FFFF_FFFF) total = 64'h0000_0000_FFFF_FFFF;
      busy = 1'b1;
      while (busy && int'(slot_lvl[s]) < N_LEVELS - 1) begin
        allowance = (64'(slot_lvl[s]) + 64'd1) * 64'(quantum);
        if (total > allowance) begin
          total       = total - allowance;
          slot_lvl[s] = slot_lvl[s] + 1'b1;
        end else begin
          busy = 1'b0;
        end
      end
      slot_rt[s] = total[RT_W-1:0];
    endfunction

    function void apply_action(logic [ACT_W-1:0] act, logic [PID_W-1:0] pid,
                               logic [ST_W-1:0] nst, logic [RT_W-1:0] run,
                               logic [TIME_W-1:0] now, logic tty);
      sched_result_t r;
      int            s;
      r = '0;
      s = -1;
      case (act)
        ACT_ALLOC: begin
          for (int i = 0; i < N_SLOTS; i++)
            if (s < 0 && slot_st[i] == ST_UNUSED) s = i;
          if (s < 0) begin
            r.table_full = 1'b1;
          end else begin
            pid_ctr     = pid_ctr + 1'b1;
            slot_pid[s] = pid_ctr;
            slot_st[s]  = ST_LOADING;
            slot_lvl[s] = '0;
            slot_rt[s]  = '0;
            r.pid       = pid_ctr;
          end
        end
        ACT_FREE, ACT_SET_ST: begin
          r.pid = pid;
          s     = find_live(pid);
          if (s >= 0) begin
            r.found   = 1'b1;
            r.level   = slot_lvl[s];
            r.runtime = slot_rt[s];
          end
          for (int i = 0; i < N_SLOTS; i++)
            if (slot_st[i] != ST_UNUSED && slot_pid[i] == pid)
              slot_st[i] = (act == ACT_FREE) ? ST_UNUSED : nst;
        end
        ACT_FREE_ALL: begin
          for (int i = 0; i < N_SLOTS; i++)
            if (slot_st[i] != ST_UNUSED && slot_pid[i] >= user_start) begin
              slot_st[i] = ST_UNUSED;
              r.found    = 1'b1;
            end
        end
        ACT_CHARGE: begin
          r.pid = pid;
          s     = find_live(pid);
          if (s >= 0) begin
            add_runtime(s, run);
            r.found   = 1'b1;
            r.level   = slot_lvl[s];
            r.runtime = slot_rt[s];
          end
        end
        ACT_TICK: begin
          r.pid = shell_pid;
          s     = find_live(shell_pid);
          if (tty && s >= 0) begin
            slot_lvl[s] = '0;
            slot_rt[s]  = '0;
          end
          if (last_reset == '0) last_reset = now;
          // elapsed time is taken modulo 2^64
          if (now - last_reset >= 64'(reset_period)) begin
            for (int i = 0; i < N_SLOTS; i++)
              if (slot_st[i] != ST_UNUSED) begin
                slot_lvl[i] = '0;
                slot_rt[i]  = '0;
              end
            last_reset     = now;
            r.levels_reset = 1'b1;
          end
          if (s >= 0) begin
            r.found   = 1'b1;
            r.level   = slot_lvl[s];
            r.runtime = slot_rt[s];
          end
        end
        default: ;
      endcase
      table_replies.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_reply(logic [M_TDATA_W-1:0] word);
      sched_result_t e;
      if (table_replies.size() == 0) begin
        $display("%0t: result transfer with no request outstanding, expected none, actual %0h",
                 $time, word);
        errors++;
        return;
      end
      e = table_replies.pop_front();
      check_field("result_pid",   e.pid,          word[OUT_LVL_LSB-1:0]);
      check_field("level_out",    e.level,        word[OUT_RT_LSB-1:OUT_LVL_LSB]);
      check_field("runtime_out",  e.runtime,      word[OUT_FOUND_BIT-1:OUT_RT_LSB]);
      check_field("found",        e.found,        word[OUT_FOUND_BIT]);
      check_field("table_full",   e.table_full,   word[OUT_FULL_BIT]);
      check_field("levels_reset", e.levels_reset, word[OUT_RESET_BIT]);
    endfunction

    function int outstanding();
      return table_replies.size();
    endfunction
  endclass

  // dut signals, all inputs known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic [ACT_W-1:0]      s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  proc_table_tracker tracker;
  int                hold_left = 0;
  int                ready_pick;
  int                cfg_phase = 0;
  int                burst_left = 0;
  logic [TIME_W-1:0] now_base = '0;

  mlfq_process_table_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stall pattern: ready runs, stall runs and coin flips,
  // one assignment of m_tready per falling edge at most
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
    end else begin
      ready_pick = $urandom_range(0, 9);
      if (ready_pick < 4) begin
        m_tready  <= 1'b1;
        hold_left = $urandom_range(0, 40);
      end else if (ready_pick < 6) begin
        m_tready  <= 1'b0;
        hold_left = $urandom_range(1, 12);
      end else begin
        m_tready  <= 1'($urandom_range(0, 1));
        hold_left = 0;
      end
    end
  end

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_reply(m_tdata);
  end

  // one request transfer; valid stays high if the caller sends again at once
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [PID_W-1:0] pid,
                           input logic [ST_W-1:0] nst, input logic [RT_W-1:0] run,
                           input logic [TIME_W-1:0] now, input logic tty);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{PAD_W{1'b0}}, tty, now, run, nst, pid};
    do @(posedge clk); while (!s_tready);
    tracker.apply_action(act, pid, nst, run, now, tty);
  endtask

  // sender gap set by n, none when n is zero
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PID_W-1:0] some_live_pid();
    int n;
    n = tracker.live_count();
    if (n == 0) return SHELL_PID_DEF;
    return tracker.live_pid($urandom_range(0, n - 1));
  endfunction

  // mostly live pids, plus random ones and a few near the interesting edges
  function automatic logic [PID_W-1:0] choose_pid();
    int k;
    k = $urandom_range(0, 99);
    if (tracker.live_count() > 0 && k < 75) return some_live_pid();
    if (k < 88) return PID_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return tracker.pid_ctr + 1'b1;   // not allocated yet
      1:       return tracker.pid_ctr;          // newest, maybe freed
      2:       return tracker.shell_pid;
      default: return tracker.user_start - 1'b1;
    endcase
  endfunction

  // settle, then move every register to the next setting
  task automatic reconfigure();
    logic [CFG_DATA_W-1:0] per;
    logic [CFG_DATA_W-1:0] qb;
    logic [CFG_DATA_W-1:0] sh;
    logic [CFG_DATA_W-1:0] us;
    settle();
    case (cfg_phase % 6)
      0: begin   // smallest period and quantum
        per = 32'd1;
        qb  = 32'd1;
        sh  = 32'(some_live_pid());
        us  = 32'd0;
      end
      1: begin   // largest values
        per = 32'hFFFF_FFFF;
        qb  = 32'(24'hFF_FFFF);
        sh  = 32'h0000_FFFF;
        us  = 32'h0000_FFFF;
      end
      2: begin
        per = $urandom_range(1, 2000);
        qb  = $urandom_range(1, 50);
        sh  = 32'(some_live_pid());
        us  = 32'(tracker.pid_ctr - 16'd4);
      end
      3: begin
        per = RESET_PERIOD_DEF;
        qb  = 32'(QUANTUM_BASE_DEF);
        sh  = 32'(some_live_pid());
        us  = 32'(some_live_pid());
      end
      4: begin
        per = $urandom_range(1, 32'hFFFF_FFFF);
        qb  = $urandom_range(1, 32'h00FF_FFFF);
        sh  = 32'($urandom_range(0, 16'hFFFF));
        us  = 32'($urandom_range(0, 16'hFFFF));
      end
      default: begin
        per = $urandom_range(1, 100000);
        qb  = $urandom_range(1, 100000);
        sh  = 32'(some_live_pid());
        us  = 32'(some_live_pid());
      end
    endcase
    write_reg(CFG_RESET_PERIOD, per);
    write_reg(CFG_QUANTUM_BASE, qb);
    write_reg(CFG_SHELL_PID, sh);
    write_reg(CFG_USER_START, us);
    cfg_phase++;
    burst_left = 0;
  endtask

  // one random request, fields shaped by the current setting
  task automatic random_item();
    logic [ACT_W-1:0]  act;
    logic [ST_W-1:0]   nst;
    logic [RT_W-1:0]   run;
    logic [TIME_W-1:0] now;
    logic [RT_W-1:0]   qb32;
    int                w;
    w = $urandom_range(0, 99);
    if (w < 22)      act = ACT_ALLOC;
    else if (w < 31) act = ACT_FREE;
    else if (w < 35) act = ACT_FREE_ALL;
    else if (w < 49) act = ACT_SET_ST;
    else if (w < 78) act = ACT_CHARGE;
    else if (w < 96) act = ACT_TICK;
    else             act = ($urandom_range(0, 1) != 0) ? ACT_RSVD_7 : ACT_RSVD_6;

    w = $urandom_range(0, 99);
    if (w < 70)      nst = ST_W'($urandom_range(1, 5));
    else if (w < 85) nst = ST_UNUSED;
    else             nst = ST_W'($urandom_range(0, 7));

    // runtime mostly around the level allowances, sometimes huge
    qb32 = RT_W'(tracker.quantum);
    w    = $urandom_range(0, 9);
    if (w < 5)      run = $urandom_range(0, qb32 * 3);
    else if (w < 7) run = $urandom_range(0, qb32 * 16);
    else if (w < 9) run = $urandom;
    else            run = 32'hFFFF_FFFF - $urandom_range(0, 3);

    // ticks follow a running clock; other actions carry noise there
    if (act == ACT_TICK) begin
      w = $urandom_range(0, 19);
      if (w == 0) begin
        now = {$urandom, $urandom};
      end else if (w == 1) begin
        now = '0;
      end else begin
        if (w < 6) now_base = now_base + 64'(tracker.reset_period) + 64'($urandom_range(0, 3));
        else       now_base = now_base + 64'($urandom) % (64'(tracker.reset_period) / 4 + 64'd1);
        now = now_base;
      end
    end else begin
      now = {$urandom, $urandom};
    end
    send_item(act, choose_pid(), nst, run, now, 1'($urandom_range(0, 1)));
  endtask

  // random traffic in bursts, new register setting every so often
  task automatic random_block(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % ITEMS_PER_CFG == 0) reconfigure();
      if (burst_left == 0) begin
        if ($urandom_range(0, 9) < 3) idle_cycles(0);
        else                          idle_cycles($urandom_range(1, 25));
        burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
      end
      burst_left--;
      random_item();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset settings (shell pid 4, user pids from 5)
    // tick at time zero on an empty table leaves the reset time unset
    send_item(ACT_TICK, '0, '0, '0, 64'd0, 1'b1);
    // charge of an unknown pid
    send_item(ACT_CHARGE, 16'hFFFF, ST_RSVD_7, 32'hFFFF_FFFF, '1, 1'b1);
    // fill all slots (pids 1..16), then allocate into a full table
    repeat (N_SLOTS + 1) send_item(ACT_ALLOC, '0, '0, '0, '0, 1'b0);
    // runtime saturates and demotion stops at the last level
    send_item(ACT_CHARGE, 16'd1, '0, 32'hFFFF_FFFF, '0, 1'b0);
    send_item(ACT_CHARGE, 16'd1, '0, 32'hFFFF_FFFF, '0, 1'b0);
    // one demotion with remainder
    send_item(ACT_CHARGE, 16'd2, '0, 32'd150000, '0, 1'b0);
    // reserved status stays live, status zero frees
    send_item(ACT_SET_ST, 16'd3, ST_RSVD_7, '0, '0, 1'b0);
    send_item(ACT_SET_ST, 16'd3, ST_UNUSED, '0, '0, 1'b0);
    send_item(ACT_SET_ST, 16'd4, ST_READY, '0, '0, 1'b0);
    // shell demoted, then boosted on pending input
    send_item(ACT_CHARGE, SHELL_PID_DEF, '0, 32'd250000, '0, 1'b0);
    send_item(ACT_TICK, '0, '0, '0, 64'd1, 1'b1);
    // time going backwards wraps to a huge difference: global reset
    send_item(ACT_TICK, '0, '0, '0, 64'd0, 1'b0);
    send_item(ACT_TICK, '0, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_item(ACT_FREE_ALL, '0, '0, '0, '0, 1'b0);
    send_item(ACT_FREE, 16'd2, '0, '0, '0, 1'b0);
    send_item(ACT_FREE, 16'd2, '0, '0, '0, 1'b0);
    // undefined actions with every data bit set
    send_item(ACT_RSVD_6, '1, '1, '1, '1, 1'b1);
    send_item(ACT_RSVD_7, '1, '1, '1, '1, 1'b1);

    random_block(ITEMS_HALF);

    // second half, registers keep moving through their settings
    random_block(ITEMS_HALF);

    settle();
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, several times the slowest expected run
  initial begin
    #100000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
